// ----- rtl/isps_pkg.sv -----
package isps_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] KIND_OVERFLOW = 2'd0;
  localparam logic [1:0] KIND_FLUSH    = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               out_kind;
    logic                     last;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/isps_cell.sv -----
module isps_cell (
  input  logic                               clk,
  input  isps_pkg::cell_ctrl_t               ctrl,
  input  logic                               occupied,
  input  logic                               prev_gt,
  input  logic signed [isps_pkg::DATA_W-1:0] prev_val,
  input  logic signed [isps_pkg::DATA_W-1:0] next_val,
  output logic                               gt,
  output logic signed [isps_pkg::DATA_W-1:0] val
);

  logic signed [isps_pkg::DATA_W-1:0] val_next;

  // empty slot counts as larger than any request value
  assign gt = !occupied || (val > ctrl.value);

  always_comb begin
    case (ctrl.op)
      isps_pkg::CELL_INSERT: begin
        if (!gt) begin
          val_next = val;
        end else if (prev_gt) begin
          val_next = prev_val;
        end else begin
          val_next = ctrl.value;
        end
      end
      isps_pkg::CELL_SHIFT: val_next = next_val;
      default:              val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ----- rtl/insertion_sort_pipeline_stage.sv -----
// insert: accepted every cycle while the output slot is free; an overflow result
//   appears in the cycle after its request, inserts into a non-full store emit nothing
// finish: n stored values then the end marker, one per cycle while the output slot is free,
//   input held off until the end marker is issued; the cell chain shifts toward cell 0
// reset (synchronous): clears fill count, flush state and output valid;
//   stored cell values are left as they are
module insertion_sort_pipeline_stage #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  isps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output isps_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic             flushing;

  logic signed [isps_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic                               cell_gt  [CAPACITY];
  isps_pkg::cell_ctrl_t               ctrl;

  logic out_free, in_fire, full, do_insert, do_finish;
  logic flush_step, emit_flush, emit_end, emit_ovf, load_out;
  isps_pkg::out_t out_next;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = !flushing && out_free;
  assign in_fire    = in_valid && in_ready;
  assign full       = count == CNT_W'(CAPACITY);
  assign do_insert  = in_fire && (in_data.command == isps_pkg::CMD_INSERT);
  assign do_finish  = in_fire && (in_data.command == isps_pkg::CMD_FINISH);
  assign flush_step = flushing && out_free;
  assign emit_flush = flush_step && (count != '0);
  assign emit_end   = flush_step && (count == '0);
  assign emit_ovf   = do_insert && full;
  assign load_out   = emit_flush || emit_end || emit_ovf;

  always_comb begin
    ctrl.value = in_data.value;
    if (do_insert) begin
      ctrl.op = isps_pkg::CELL_INSERT;
    end else if (emit_flush) begin
      ctrl.op = isps_pkg::CELL_SHIFT;
    end else begin
      ctrl.op = isps_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
    isps_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (count > CNT_W'(i)),
      .prev_gt  ((i == 0) ? 1'b0 : cell_gt[PREV]),
      .prev_val ((i == 0) ? in_data.value : cell_val[PREV]),
      .next_val (cell_val[NEXT]),
      .gt       (cell_gt[i]),
      .val      (cell_val[i])
    );
  end

  always_comb begin
    out_next.last = 1'b0;
    if (emit_end) begin
      out_next.out_value = '0;
      out_next.out_kind  = isps_pkg::KIND_END;
      out_next.last      = 1'b1;
    end else if (emit_flush) begin
      out_next.out_value = cell_val[0];
      out_next.out_kind  = isps_pkg::KIND_FLUSH;
    end else begin
      // largest of the full store and the new value
      out_next.out_value = cell_gt[CAPACITY-1] ? cell_val[CAPACITY-1] : in_data.value;
      out_next.out_kind  = isps_pkg::KIND_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      flushing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_insert && !full) begin
        count <= count + CNT_W'(1);
      end else if (emit_flush) begin
        count <= count - CNT_W'(1);
      end
      if (do_finish) begin
        flushing <= 1'b1;
      end else if (emit_end) begin
        flushing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_flush_blocks: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !in_ready)
    else $error("request taken during flush");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (count == '0 && !flushing &&
      out_data.out_kind == isps_pkg::KIND_END))
    else $error("end marker with store not empty");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    emit_ovf |=> (out_valid && count == CNT_W'(CAPACITY)))
    else $error("overflow result without full store");
`endif

endmodule

// ----- tb/sv/tb_insertion_sort_pipeline_stage.sv -----
`timescale 1ns / 100ps

module tb_insertion_sort_pipeline_stage;

  localparam int CAPACITY = 32;
  localparam int RX_HOLD_CYCLES = 300;
  localparam logic signed [isps_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [isps_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  isps_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  isps_pkg::out_t out_data;

  insertion_sort_pipeline_stage #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  logic signed [isps_pkg::DATA_W-1:0] sorted_copy [CAPACITY];
  int                                 stored_count;
  isps_pkg::out_t                     pending_results [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_request;
  int rx_hold_seen;
  int rx_hold_left;
  int run_left;

  int mismatch_count = 0;
  int request_count;
  int result_count = 0;
  int overflow_count;
  int flush_runs;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void push_expected(input logic signed [isps_pkg::DATA_W-1:0] v,
                                        input logic [1:0] kind, input logic lst);
    isps_pkg::out_t r;
    r.out_value = v;
    r.out_kind  = kind;
    r.last      = lst;
    pending_results.push_back(r);
  endfunction

  // keeps a sorted copy of the store and queues the results of one request
  function automatic void predict_sort_results(input isps_pkg::in_t req);
    logic signed [isps_pkg::DATA_W-1:0] v;
    logic signed [isps_pkg::DATA_W-1:0] t;
    int j;
    v = req.value;
    if (req.command == isps_pkg::CMD_FINISH) begin
      for (j = 0; j < stored_count; j++) begin
        push_expected(sorted_copy[j], isps_pkg::KIND_FLUSH, 1'b0);
      end
      push_expected('0, isps_pkg::KIND_END, 1'b1);
      stored_count = 0;
      flush_runs++;
    end else if (stored_count < CAPACITY) begin
      j = stored_count;
      while (j > 0 && sorted_copy[j-1] > v) begin
        sorted_copy[j] = sorted_copy[j-1];
        j--;
      end
      sorted_copy[j] = v;
      stored_count++;
    end else begin
      for (j = 0; j < CAPACITY; j++) begin
        if (v < sorted_copy[j]) begin
          t = sorted_copy[j];
          sorted_copy[j] = v;
          v = t;
        end
      end
      push_expected(v, isps_pkg::KIND_OVERFLOW, 1'b0);
      overflow_count++;
    end
  endfunction

  task automatic send_request(input logic cmd,
                              input logic signed [isps_pkg::DATA_W-1:0] val);
    isps_pkg::in_t req;
    req.command = cmd;
    req.value   = val;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sort_results(req);
    request_count++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [isps_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // receiver side: random stalls plus a long hold-off on request
  initial begin : receiver
    out_ready = 1'b0;
    rx_hold_seen = 0;
    rx_hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_request != rx_hold_seen) begin
        rx_hold_seen = rx_hold_request;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    isps_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", int'(out_data.out_kind), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_value !== want.out_value)
          report_mismatch("out_value", int'(out_data.out_value), int'(want.out_value));
        if (out_data.out_kind !== want.out_kind)
          report_mismatch("out_kind", int'(out_data.out_kind), int'(want.out_kind));
        if (out_data.last !== want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
      end
    end
  end

  task automatic test_directed_extremes();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_request(isps_pkg::CMD_FINISH, 32'sd0);
    send_request(isps_pkg::CMD_INSERT, VAL_MAX);
    send_request(isps_pkg::CMD_INSERT, VAL_MIN);
    send_request(isps_pkg::CMD_INSERT, 32'sd0);
    send_request(isps_pkg::CMD_INSERT, -32'sd1);
    send_request(isps_pkg::CMD_INSERT, 32'sd1);
    send_request(isps_pkg::CMD_INSERT, 32'sd5);
    send_request(isps_pkg::CMD_INSERT, 32'sd5);
    send_request(isps_pkg::CMD_INSERT, -32'sd1);
    send_request(isps_pkg::CMD_INSERT, VAL_MAX);
    send_request(isps_pkg::CMD_INSERT, VAL_MIN);
    send_request(isps_pkg::CMD_FINISH, 32'h5555_aaaa);
    send_request(isps_pkg::CMD_INSERT, 32'sh0f0f_f0f0);
    send_request(isps_pkg::CMD_FINISH, VAL_MIN);
    send_request(isps_pkg::CMD_FINISH, VAL_MAX);
    release_input();
  endtask

  // fills the store while the receiver holds off, then overflows at both extremes
  task automatic test_output_stall();
    int i;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_request++;
    for (i = 0; i < CAPACITY; i++) send_request(isps_pkg::CMD_INSERT, random_value());
    send_request(isps_pkg::CMD_INSERT, VAL_MAX);
    send_request(isps_pkg::CMD_INSERT, VAL_MIN);
    send_request(isps_pkg::CMD_INSERT, random_value());
    send_request(isps_pkg::CMD_INSERT, random_value());
    release_input();
    wait_drained();
    send_request(isps_pkg::CMD_INSERT, random_value());
    send_request(isps_pkg::CMD_FINISH, random_value());
    release_input();
  endtask

  // inserts with an occasional finish; runs carry over between calls, long ones overflow
  task automatic test_random_runs(input int n_items, input int tx_pct, input int rx_pct);
    int i;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        send_request(isps_pkg::CMD_FINISH, $urandom);
        if ($urandom_range(0, 3) == 0) run_left = $urandom_range(0, 8);
        else run_left = $urandom_range(34, 45);
      end else begin
        send_request(isps_pkg::CMD_INSERT, random_value());
        run_left--;
      end
    end
    release_input();
    wait_drained();
  endtask

  // empties whatever the random runs left in the store
  task automatic test_final_flush();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_request(isps_pkg::CMD_FINISH, $urandom);
    release_input();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_request = 0;
    run_left = 36;
    stored_count = 0;
    request_count = 0;
    overflow_count = 0;
    flush_runs = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_output_stall();
    test_random_runs(18, 34, 83);
    test_random_runs(18, 83, 34);
    test_random_runs(18, 0, 0);
    test_final_flush();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sorted %0d requests into %0d checked results", request_count, result_count);
    $display("%0d overflow values passed on, %0d finish flushes", overflow_count, flush_runs);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
